>>> hdl/toroidal_volume_origin_update_macros.svh
// Assertion macros for the toroidal volume origin update block.
// No dependencies; included by the top level only.
`ifndef TOROIDAL_VOLUME_ORIGIN_UPDATE_MACROS_SVH
`define TOROIDAL_VOLUME_ORIGIN_UPDATE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define TVO_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tvo assertion failed");
// next-cycle implication, disabled during reset
`define TVO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tvo assertion failed");
`else
`define TVO_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TVO_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/tvo_pkg.sv
// Shared types and constants for the toroidal volume origin update block.
// No dependencies; used by every module of the block.
`default_nettype none

package tvo_pkg;

   // default configuration
   localparam int RES_X_DEF    = 64;
   localparam int RES_Y_DEF    = 32;
   localparam int RES_Z_DEF    = 64;
   localparam int CASCADES_DEF = 3;

   // field widths
   localparam int COORD_W   = 20;
   localparam int CASCADE_W = 2;
   localparam int EXTENT_W  = 7;
   localparam int THRESH_W  = 7;

   localparam logic [THRESH_W-1:0] MOVE_THRESHOLD_RST = 7'd4;

   typedef enum logic [1:0] {
      ST_NOT_MOVED = 2'd0,
      ST_MOVED     = 2'd1,
      ST_TELEPORT  = 2'd2
   } status_type;

   typedef struct packed {
      logic [CASCADE_W-1:0]      cascade;
      logic signed [COORD_W-1:0] target_x;
      logic signed [COORD_W-1:0] target_y;
      logic signed [COORD_W-1:0] target_z;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] start_z;
      logic [EXTENT_W-1:0]       extent_x;
      logic [EXTENT_W-1:0]       extent_y;
      logic [EXTENT_W-1:0]       extent_z;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
   } rsp_type;

   // cascade state write port
   typedef struct packed {
      logic                      en;
      logic [CASCADE_W-1:0]      cascade;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
   } wr_type;

   // cascade state read data
   typedef struct packed {
      logic                      valid;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
   } rd_type;

endpackage

`default_nettype wire

>>> hdl/tvo_store.sv
// Per-cascade origin registers and valid flags, one read and one write port.
// Depends on tvo_pkg.
`default_nettype none

module tvo_store #(
   parameter int CASCADES = tvo_pkg::CASCADES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [tvo_pkg::CASCADE_W-1:0]  rd_cascade,
   output tvo_pkg::rd_type                     rd,
   input  wire tvo_pkg::wr_type                wr
);

   logic                                  valid_ff [CASCADES];
   logic signed [tvo_pkg::COORD_W-1:0]    org_x_ff [CASCADES];
   logic signed [tvo_pkg::COORD_W-1:0]    org_y_ff [CASCADES];
   logic signed [tvo_pkg::COORD_W-1:0]    org_z_ff [CASCADES];

   // valid flags: cleared at reset, set by any write
   always_ff @(posedge clock) begin
      for (int i = 0; i < CASCADES; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (wr.en && (int'(wr.cascade) == i)) begin
            valid_ff[i] <= 1'b1;
         end
      end
   end

   // origins: contents matter only once the flag is set
   always_ff @(posedge clock) begin
      for (int i = 0; i < CASCADES; i++) begin
         if (wr.en && (int'(wr.cascade) == i)) begin
            org_x_ff[i] <= wr.origin_x;
            org_y_ff[i] <= wr.origin_y;
            org_z_ff[i] <= wr.origin_z;
         end
      end
   end

   // read select; an index past the last cascade reads zero
   always_comb begin
      rd = '0;
      for (int i = 0; i < CASCADES; i++) begin
         if (int'(rd_cascade) == i) begin
            rd.valid    = valid_ff[i];
            rd.origin_x = org_x_ff[i];
            rd.origin_y = org_y_ff[i];
            rd.origin_z = org_z_ff[i];
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/tvo_step.sv
// Update decision for one item: move, largest axis, teleport, invalid region.
// Depends on tvo_pkg.
`default_nettype none

module tvo_step #(
   parameter int RES_X = tvo_pkg::RES_X_DEF,
   parameter int RES_Y = tvo_pkg::RES_Y_DEF,
   parameter int RES_Z = tvo_pkg::RES_Z_DEF
) (
   input  wire tvo_pkg::req_type              req,
   input  wire logic                          in_range,
   input  wire tvo_pkg::rd_type               rd,
   input  wire logic [tvo_pkg::THRESH_W-1:0]  threshold,
   output tvo_pkg::rsp_type                   rsp,
   output tvo_pkg::wr_type                    wr
);

   localparam int CW = tvo_pkg::COORD_W;
   localparam int MW = CW + 1;
   localparam int RES_A [3] = '{RES_X, RES_Y, RES_Z};

   logic [CW-1:0]         tgt   [3];
   logic [CW-1:0]         org   [3];
   logic signed [MW-1:0]  mv    [3];
   logic [MW-1:0]         am    [3];
   logic [2:0]            far;
   logic [2:0]            sel;
   logic [2:0]            moved;
   logic [CW-1:0]         nxt   [3];
   logic [CW-1:0]         lt    [3];
   logic [CW-1:0]         st    [3];
   logic [tvo_pkg::EXTENT_W-1:0] ext [3];
   logic [MW-1:0]         mx;
   logic                  hold;
   logic                  teleport;

   assign tgt[0] = req.target_x;
   assign tgt[1] = req.target_y;
   assign tgt[2] = req.target_z;
   assign org[0] = rd.origin_x;
   assign org[1] = rd.origin_y;
   assign org[2] = rd.origin_z;

   // per-axis move and magnitude
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mv[i]  = {org[i][CW-1], org[i]} - {tgt[i][CW-1], tgt[i]};
         am[i]  = mv[i][MW-1] ? MW'(-mv[i]) : MW'(mv[i]);
         far[i] = am[i] >= MW'(RES_A[i]);
      end
   end

   // largest axis, ties go X, then Z, then Y
   always_comb begin
      sel[0] = (am[0] >= am[1]) && (am[0] >= am[2]);
      sel[2] = !sel[0] && (am[2] >= am[1]);
      sel[1] = !sel[0] && !sel[2];
      mx     = sel[0] ? am[0] : (sel[2] ? am[2] : am[1]);
      hold     = rd.valid && (mx < MW'(threshold));
      teleport = !rd.valid || (|far);
   end

   // new origin and invalid region per axis
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         moved[i] = !teleport && sel[i];
         nxt[i]   = (teleport || moved[i]) ? tgt[i] : org[i];
         lt[i]    = nxt[i] - CW'(RES_A[i] / 2);
         st[i]    = (moved[i] && mv[i][MW-1]) ? (lt[i] + CW'(RES_A[i]) + mv[i][CW-1:0])
                                              : lt[i];
         ext[i]   = moved[i] ? am[i][tvo_pkg::EXTENT_W-1:0]
                             : tvo_pkg::EXTENT_W'(RES_A[i]);
      end
   end

   // result assembly
   always_comb begin
      rsp = '0;
      if (in_range && hold) begin
         rsp.status   = tvo_pkg::ST_NOT_MOVED;
         rsp.origin_x = org[0];
         rsp.origin_y = org[1];
         rsp.origin_z = org[2];
      end else if (in_range) begin
         rsp.status   = teleport ? tvo_pkg::ST_TELEPORT : tvo_pkg::ST_MOVED;
         rsp.start_x  = st[0];
         rsp.start_y  = st[1];
         rsp.start_z  = st[2];
         rsp.extent_x = ext[0];
         rsp.extent_y = ext[1];
         rsp.extent_z = ext[2];
         rsp.origin_x = nxt[0];
         rsp.origin_y = nxt[1];
         rsp.origin_z = nxt[2];
      end
   end

   // state write-back request
   always_comb begin
      wr.en       = in_range && !hold;
      wr.cascade  = req.cascade;
      wr.origin_x = nxt[0];
      wr.origin_y = nxt[1];
      wr.origin_z = nxt[2];
   end

endmodule

`default_nettype wire

>>> hdl/toroidal_volume_origin_update.sv
// Toroidal volume origin update: one update request in, one result out.
//
// req_valid/req_ready/req_data carry a cascade index and a target texel
// origin. rsp_valid/rsp_ready/rsp_data carry the status (not moved, moved
// one axis, teleported), the invalid region start and extent, and the
// cascade origin after the update. csr_valid/csr_ready/csr_data write the
// move threshold; csr_ready is always high, write only while idle.
// The request passes the input register, then the result register, before
// rsp_valid rises. Throughput: one request per cycle while the result is
// not stalled; the per-cascade origin registers are read and written back
// as the item moves into the result register.
// A stalled result holds in the result register; the input register
// still takes one more request, after which req_ready drops.
// Reset clears both registers' valid flags, sets the threshold to 4 and
// marks every cascade invalid, so the first request to each teleports.
// Depends on tvo_pkg, tvo_store, tvo_step and the macros header.
`default_nettype none
`include "toroidal_volume_origin_update_macros.svh"

module toroidal_volume_origin_update #(
   parameter int RES_X    = tvo_pkg::RES_X_DEF,
   parameter int RES_Y    = tvo_pkg::RES_Y_DEF,
   parameter int RES_Z    = tvo_pkg::RES_Z_DEF,
   parameter int CASCADES = tvo_pkg::CASCADES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire tvo_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output tvo_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tvo_pkg::THRESH_W-1:0]  csr_data
);

   logic                         req_valid_ff, req_valid_in;
   tvo_pkg::req_type             req_ff, req_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   tvo_pkg::rsp_type             rsp_ff, rsp_in;
   logic [tvo_pkg::THRESH_W-1:0] thresh_ff, thresh_in;
   logic                         advance;
   logic                         in_range;
   tvo_pkg::rd_type              rd;
   tvo_pkg::wr_type              step_wr;
   tvo_pkg::wr_type              wr;

   // handshake control
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign in_range  = int'(req_ff.cascade) < CASCADES;

   // next-state logic for the stage registers
   always_comb begin
      req_valid_in = (req_valid && req_ready) || (req_valid_ff && !advance);
      req_in       = (req_valid && req_ready) ? req_data : req_ff;
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
      thresh_in    = (csr_valid && csr_ready) ? csr_data : thresh_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thresh_ff    <= tvo_pkg::MOVE_THRESHOLD_RST;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         thresh_ff    <= thresh_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // state written only when the item moves to the result register
   always_comb begin
      wr    = step_wr;
      wr.en = step_wr.en && advance;
   end

   tvo_store #(
      .CASCADES (CASCADES)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .rd_cascade (req_ff.cascade),
      .rd         (rd),
      .wr         (wr)
   );

   tvo_step #(
      .RES_X (RES_X),
      .RES_Y (RES_Y),
      .RES_Z (RES_Z)
   ) u_step (
      .req       (req_ff),
      .in_range  (in_range),
      .rd        (rd),
      .threshold (thresh_ff),
      .rsp       (rsp_in),
      .wr        (step_wr)
   );

   // a held item with a free result register moves on
   `TVO_ASSERT_NEXT(a_advance, clock, reset, req_valid_ff && !rsp_valid_ff, rsp_valid_ff)
   // no move reported means an empty invalid region
   `TVO_ASSERT_IMPL(a_hold_ext, clock, reset,
      rsp_valid && (rsp_data.status == tvo_pkg::ST_NOT_MOVED),
      (rsp_data.extent_x == '0) && (rsp_data.extent_y == '0) && (rsp_data.extent_z == '0))
   // teleport invalidates the whole volume along X and Y
   `TVO_ASSERT_IMPL(a_tele_ext, clock, reset,
      rsp_valid && (rsp_data.status == tvo_pkg::ST_TELEPORT),
      (rsp_data.extent_y == tvo_pkg::EXTENT_W'(RES_Y)) &&
      (rsp_data.extent_x == tvo_pkg::EXTENT_W'(RES_X)))
   // the store is written only on a transfer into the result register
   `TVO_ASSERT_IMPL(a_wr_adv, clock, reset, wr.en, advance && in_range)

endmodule

`default_nettype wire
